// ===== design/acce_pkg.sv =====
`default_nettype none
package acce_pkg;
  localparam int unsigned ColorCount = 256;
  localparam int unsigned ColorW = 8;
  localparam int unsigned BinW = $clog2(ColorCount);
  localparam int unsigned CountW = 7;
  localparam logic [7:0] InkReset = 8'h0f;
  localparam logic [7:0] PaperReset = 8'h08;
  localparam logic [2:0] HueMask = 3'h7;
  localparam logic [2:0] DarkHue = 3'h1;

  localparam logic [0:0] RegDefaultColor = 1'b0;
  localparam logic [0:0] RegSpriteMode = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_row;   // store and start counting an accepted row
    logic count_pix;  // count one pixel of the held row
    logic scan_bin;   // compare one histogram bin against the top three
    logic scan_init;  // clear the top-three registers
    logic choose;     // run the ink/paper choice
    logic emit;       // drive one output word
  } acce_cmd_t;
endpackage
`default_nettype wire

// ===== design/acce_ctrl.sv =====
`default_nettype none
module acce_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output acce_pkg::acce_cmd_t cmd_o,
  output logic [2:0] pix_idx_o,
  output logic [2:0] row_idx_o,
  output logic [acce_pkg::BinW-1:0] bin_idx_o,
  output logic busy_o
);
  import acce_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StCount, StScan, StScanEnd, StChoose, StEmit
  } state_e;

  state_e state_q;
  logic [2:0] pix_q, row_q, emit_q;
  logic [BinW-1:0] bin_q;
  logic phase_q;

  // Each pixel is counted in a histogram read phase, then a write phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pix_q <= '0;
      row_q <= '0;
      emit_q <= '0;
      bin_q <= '0;
      phase_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StCount;
            pix_q <= '0;
            phase_q <= 1'b0;
          end
        end
        StCount: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            pix_q <= pix_q + 3'd1;
            if (pix_q == 3'd7) begin
              if (row_q == 3'd7) begin
                state_q <= StScan;
                bin_q <= BinW'(1);
              end else begin
                state_q <= StIdle;
              end
              row_q <= row_q + 3'd1;
            end
          end
        end
        StScan: begin
          bin_q <= bin_q + BinW'(1);
          if (bin_q == BinW'(ColorCount - 1)) state_q <= StScanEnd;
        end
        StScanEnd: begin
          state_q <= StChoose;
        end
        StChoose: begin
          state_q <= StEmit;
          emit_q <= '0;
        end
        StEmit: begin
          emit_q <= emit_q + 3'd1;
          if (emit_q == 3'd7) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.load_row = (state_q == StIdle) && start_i;
    cmd_o.scan_init = cmd_o.load_row && (row_q == 3'd0);
    cmd_o.count_pix = (state_q == StCount) && phase_q;
    cmd_o.scan_bin = (state_q == StScan);
    cmd_o.choose = (state_q == StChoose);
    cmd_o.emit = (state_q == StEmit);
  end

  assign pix_idx_o = pix_q;
  assign row_idx_o = (state_q == StEmit) ? emit_q : row_q;
  assign bin_idx_o = bin_q;
  assign busy_o = (state_q != StIdle);
endmodule
`default_nettype wire

// ===== design/acce_datapath.sv =====
`default_nettype none
module acce_datapath (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  acce_pkg::acce_cmd_t cmd_i,
  input  wire logic [2:0] pix_idx_i,
  input  wire logic [2:0] row_idx_i,
  input  wire logic [acce_pkg::BinW-1:0] bin_idx_i,
  input  wire logic [63:0] row_pixels_i,
  input  wire logic band_start_i,
  input  wire logic [7:0] default_color_i,
  input  wire logic sprite_mode_i,
  output logic result_valid_o,
  output logic [7:0] pixel_byte_o,
  output logic [7:0] mask_byte_o,
  output logic [7:0] attribute_o,
  output logic last_o
);
  import acce_pkg::*;

  // Histogram memory with one registered read port, shared by counting and
  // scanning. A bin whose valid bit is clear reads as zero; the valid bits
  // are cleared when the pair is chosen.
  logic [CountW-1:0] hist_mem [ColorCount];
  logic [ColorCount-1:0] hist_vld_q;
  logic [63:0] rows_q [8];
  logic [63:0] cur_row_q;
  logic [7:0] ink_q, paper_q, prev_ink_q, prev_paper_q;
  logic [7:0] c1_q, c2_q, c3_q;
  logic [CountW-1:0] n1_q, n2_q, n3_q;
  logic [7:0] pix;
  logic [BinW-1:0] rd_addr, rd_col_q;
  logic [CountW-1:0] rd_data_q, rd_cnt;
  logic rd_vld_q, scan_q;
  logic [7:0] bin_col;

  assign pix = cur_row_q[63 - 8*pix_idx_i -: 8];
  assign rd_addr = cmd_i.scan_bin ? bin_idx_i : pix[BinW-1:0];
  assign rd_cnt = rd_vld_q ? rd_data_q : '0;
  assign bin_col = 8'(rd_col_q);

  always_ff @(posedge clk_i) begin
    rd_data_q <= hist_mem[rd_addr];
    if (cmd_i.count_pix && (32'(pix) < ColorCount))
      hist_mem[pix[BinW-1:0]] <= rd_cnt + CountW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      rd_vld_q <= 1'b0;
      rd_col_q <= '0;
      scan_q <= 1'b0;
    end else begin
      rd_vld_q <= hist_vld_q[rd_addr];
      rd_col_q <= rd_addr;
      scan_q <= cmd_i.scan_bin;
      if (cmd_i.count_pix && (32'(pix) < ColorCount)) begin
        hist_vld_q[pix[BinW-1:0]] <= 1'b1;
      end else if (cmd_i.choose) begin
        hist_vld_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row) begin
      cur_row_q <= row_pixels_i;
      rows_q[row_idx_i] <= row_pixels_i;
    end
    if (cmd_i.scan_init) begin
      c1_q <= '0; c2_q <= '0; c3_q <= '0;
      n1_q <= '0; n2_q <= '0; n3_q <= '0;
    end else if (scan_q) begin
      if (rd_cnt > n1_q) begin
        c3_q <= c2_q; n3_q <= n2_q;
        c2_q <= c1_q; n2_q <= n1_q;
        c1_q <= bin_col; n1_q <= rd_cnt;
      end else if (rd_cnt > n2_q) begin
        c3_q <= c2_q; n3_q <= n2_q;
        c2_q <= bin_col; n2_q <= rd_cnt;
      end else if (rd_cnt > n3_q) begin
        c3_q <= bin_col; n3_q <= rd_cnt;
      end
    end
  end

  // Ink and paper choice with sprite mode, continuity, default and dark-ink swap.
  logic [7:0] a_ink, a_pap, ci, cp, fi, fp;
  always_comb begin
    a_ink = c1_q;
    a_pap = (c2_q[2:0] == c1_q[2:0]) ? c3_q : c2_q;
    if (sprite_mode_i) begin
      a_ink = InkReset;
      a_pap = PaperReset;
    end
    if ((a_ink[2:0] == prev_ink_q[2:0]) || (a_pap[2:0] == prev_paper_q[2:0])) begin
      ci = a_ink; cp = a_pap;
    end else if ((a_pap[2:0] == prev_ink_q[2:0]) || (a_ink[2:0] == prev_paper_q[2:0])) begin
      ci = a_pap; cp = a_ink;
    end else if (a_ink > a_pap) begin
      ci = a_ink; cp = a_pap;
    end else begin
      ci = a_pap; cp = a_ink;
    end
    if (ci == '0) ci = default_color_i;
    if (cp == '0) cp = default_color_i;
    if ((ci[2:0] <= DarkHue) && (cp[2:0] > ci[2:0])) begin
      fi = cp; fp = ci;
    end else begin
      fi = ci; fp = cp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ink_q <= InkReset;
      prev_paper_q <= PaperReset;
    end else if (cmd_i.load_row && band_start_i) begin
      prev_ink_q <= InkReset;
      prev_paper_q <= PaperReset;
    end else if (cmd_i.choose) begin
      prev_ink_q <= fi;
      prev_paper_q <= fp;
    end
  end
  assign ink_q = prev_ink_q;
  assign paper_q = prev_paper_q;

  logic [7:0] pb, mb, attr, bi, bp;
  always_comb begin
    for (int p = 0; p < 8; p++) begin
      pb[7-p] = (rows_q[row_idx_i][63-8*p -: 8] == ink_q);
      mb[7-p] = (rows_q[row_idx_i][63-8*p -: 8] != 8'h00);
    end
    bi = (ink_q != PaperReset) ? ink_q : 8'h00;
    bp = (paper_q != PaperReset) ? paper_q : 8'h00;
    attr = {1'b0, bi[3] | bp[3], paper_q[2:0] & HueMask, ink_q[2:0] & HueMask};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
      last_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.emit;
      last_o <= cmd_i.emit && (row_idx_i == 3'd7);
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_byte_o <= pb;
    mask_byte_o <= mb;
    attribute_o <= (row_idx_i == 3'd7) ? attr : 8'h00;
  end
endmodule
`default_nettype wire

// ===== design/attribute_cell_color_encoder_core.sv =====
`default_nettype none
// Channel   | Ports                                         | Handshake
// ----------+-----------------------------------------------+---------------------------
// input     | row_pixels_i, band_start_i                    | start_i high, busy_o low
// result    | pixel_byte_o, mask_byte_o, attribute_o, last_o | result_valid_o, one cycle
// config    | psel, penable, pwrite, paddr, pwdata, prdata  | APB, pready always high
//
// Each row word is accepted in the idle state, then its eight pixels are counted,
// each with a histogram read step followed by a write step. On the
// eighth row the controller scans the 255 bins one per cycle, waits in a
// scan-end state for the last registered read, chooses ink and paper in a
// choose state, then sends eight result words on consecutive cycles, each
// registered in the cycle after its emit cycle. Reset clears control state and
// the histogram valid bits; the receiver cannot stall, so results are never held
// back.
module attribute_cell_color_encoder_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic busy_o,
  input  wire logic [63:0] row_pixels_i,
  input  wire logic band_start_i,
  output logic result_valid_o,
  output logic [7:0] pixel_byte_o,
  output logic [7:0] mask_byte_o,
  output logic [7:0] attribute_o,
  output logic last_o,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import acce_pkg::*;

  acce_cmd_t cmd;
  logic [2:0] pix_idx, row_idx;
  logic [BinW-1:0] bin_idx;
  logic [7:0] default_color_q;
  logic sprite_mode_q;

  // Registers are at byte addresses 0 and 4; bit 2 selects between them and bits 1:0 must be zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_color_q <= '0;
      sprite_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[1:0] == 2'b00)) begin
      if (paddr[2] == RegDefaultColor) default_color_q <= pwdata[7:0];
      else sprite_mode_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegSpriteMode) prdata = {31'd0, sprite_mode_q};
      else prdata = {24'd0, default_color_q};
    end
  end
  assign pready = 1'b1;

  acce_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i,
    .cmd_o(cmd), .pix_idx_o(pix_idx), .row_idx_o(row_idx),
    .bin_idx_o(bin_idx), .busy_o
  );

  acce_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .pix_idx_i(pix_idx), .row_idx_i(row_idx),
    .bin_idx_i(bin_idx), .row_pixels_i, .band_start_i,
    .default_color_i(default_color_q), .sprite_mode_i(sprite_mode_q),
    .result_valid_o, .pixel_byte_o, .mask_byte_o, .attribute_o, .last_o
  );
endmodule
`default_nettype wire

// ===== dv/tb_attribute_cell_color_encoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Self-checking bench for the attribute cell colour encoder.
// Rows are sent as command words. A bench model keeps its own histogram and
// its own band continuity state. On every eighth row it computes the eight
// expected bitmap/mask words and queues them. Each strobed result word is
// compared against the oldest queued word.
module tb_attribute_cell_color_encoder_core;
  import acce_pkg::*;

  localparam int unsigned RandomRows = 184;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned DrainCycles = 300;

  typedef struct packed {
    logic [7:0] pix;
    logic [7:0] msk;
    logic [7:0] attr;
    logic       last;
  } cell_word_t;

  // Directed stimulus row; has_attr marks rows whose attribute is known by hand.
  typedef struct packed {
    logic [63:0] row;
    logic        band;
    logic        has_attr;
    logic [7:0]  attr;
  } row_step_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [63:0] row_pixels_i;
  logic        band_start_i;
  logic        result_valid_o;
  logic [7:0]  pixel_byte_o;
  logic [7:0]  mask_byte_o;
  logic [7:0]  attribute_o;
  logic        last_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  attribute_cell_color_encoder_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .row_pixels_i, .band_start_i,
    .result_valid_o, .pixel_byte_o, .mask_byte_o, .attribute_o, .last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Bench copy of the block's state.
  logic [7:0]  mdl_default;
  logic        mdl_sprite;
  logic [63:0] mdl_rows [8];
  logic [2:0]  mdl_row_idx;
  logic [6:0]  mdl_hist [ColorCount];
  logic [7:0]  mdl_ink;
  logic [7:0]  mdl_paper;

  cell_word_t  words_due [$];
  int unsigned errors;
  int unsigned idle_cycles;
  bit          no_gaps;

  // Checked words have no further effect. This holds the attribute of the last cell
  // completed, so a directed row can be compared against its typed attribute.
  logic [7:0]  last_attr_due;

  function automatic logic [7:0] px(input logic [63:0] row, input int unsigned p);
    return row[63 - 8 * p -: 8];
  endfunction

  // Adds one row to the bench histogram. On the eighth row it also queues the
  // eight expected words.
  task automatic encode_row(input logic [63:0] row, input logic band);
    logic [7:0] c1, c2, c3, ink, paper, ci, cp, t, b, b0, c, attr;
    logic [6:0] n1, n2, n3;
    cell_word_t w;
    if (band) begin
      mdl_ink = InkReset;
      mdl_paper = PaperReset;
    end
    mdl_rows[mdl_row_idx] = row;
    for (int p = 0; p < 8; p++) begin
      mdl_hist[px(row, p)] = mdl_hist[px(row, p)] + 7'd1;
    end
    if (mdl_row_idx != 3'd7) begin
      mdl_row_idx = mdl_row_idx + 3'd1;
      return;
    end
    mdl_row_idx = '0;
    // Top three colours. A later colour wins only on a strictly higher count,
    // so the lower index keeps ties. Colour 0 is left out.
    c1 = '0; c2 = '0; c3 = '0; n1 = '0; n2 = '0; n3 = '0;
    for (int i = 1; i < ColorCount; i++) begin
      if (mdl_hist[i] > n1) begin
        c3 = c2; n3 = n2; c2 = c1; n2 = n1; c1 = 8'(i); n1 = mdl_hist[i];
      end else if (mdl_hist[i] > n2) begin
        c3 = c2; n3 = n2; c2 = 8'(i); n2 = mdl_hist[i];
      end else if (mdl_hist[i] > n3) begin
        c3 = 8'(i); n3 = mdl_hist[i];
      end
    end
    if (c2[2:0] == c1[2:0]) begin
      c2 = c3;
    end
    ink = c1;
    paper = c2;
    if (mdl_sprite) begin
      ink = InkReset;
      paper = PaperReset;
    end
    // Keep the pair's order in line with the previous cell of the band.
    if (ink[2:0] == mdl_ink[2:0] || paper[2:0] == mdl_paper[2:0]) begin
      ci = ink; cp = paper;
    end else if (paper[2:0] == mdl_ink[2:0] || ink[2:0] == mdl_paper[2:0]) begin
      ci = paper; cp = ink;
    end else if (ink > paper) begin
      ci = ink; cp = paper;
    end else begin
      ci = paper; cp = ink;
    end
    if (ci == 0) begin
      ci = mdl_default;
    end
    if (cp == 0) begin
      cp = mdl_default;
    end
    // A dark ink is swapped with a lighter paper.
    if (ci[2:0] <= DarkHue && cp[2:0] > ci[2:0]) begin
      t = cp; cp = ci; ci = t;
    end
    mdl_ink = ci;
    mdl_paper = cp;
    for (int i = 0; i < ColorCount; i++) begin
      mdl_hist[i] = '0;
    end
    b = (ci != PaperReset) ? ci : 8'd0;
    b0 = (cp != PaperReset) ? cp : 8'd0;
    attr = {1'b0, b[3] | b0[3], cp[2:0], ci[2:0]};
    last_attr_due = attr;
    for (int r = 0; r < 8; r++) begin
      w = '0;
      for (int p = 0; p < 8; p++) begin
        c = px(mdl_rows[r], p);
        w.pix[7 - p] = (c == ci);
        w.msk[7 - p] = (c != 0);
      end
      w.attr = (r == 7) ? attr : 8'd0;
      w.last = (r == 7);
      words_due.push_back(w);
    end
  endtask

  // Every result word is compared against the oldest expected word.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (words_due.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        cell_word_t w;
        w = words_due.pop_front();
        if (pixel_byte_o !== w.pix) begin
          $error("pixel_byte expected %h actual %h", w.pix, pixel_byte_o);
          errors++;
        end
        if (mask_byte_o !== w.msk) begin
          $error("mask_byte expected %h actual %h", w.msk, mask_byte_o);
          errors++;
        end
        if (attribute_o !== w.attr) begin
          $error("attribute expected %h actual %h", w.attr, attribute_o);
          errors++;
        end
        if (last_o !== w.last) begin
          $error("last expected %b actual %b", w.last, last_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither a row nor a result is accepted.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic reg_write(input logic [0:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegDefaultColor) begin
      mdl_default = val;
    end else begin
      mdl_sprite = val[0];
    end
  endtask

  // Sends one row word. An optional random gap comes first: start_i drops and
  // the block is let go idle. Without a
  // gap, start_i stays high so the next word is taken as soon as busy_o falls.
  task automatic send_row(input logic [63:0] row, input logic band);
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      @(posedge clk_i);
      while (busy_o) begin
        @(posedge clk_i);
      end
      repeat ($urandom_range(0, 8)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    row_pixels_i <= row;
    band_start_i <= band;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    encode_row(row, band);
  endtask

  // Stops sending, waits until every expected word is back, then lets the
  // block settle.
  task automatic drain();
    start_i <= 1'b0;
    while (words_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Random row. Colours come from a small palette of five
  // entries, so the count ranking and the hue clash get exercised. Some
  // pixels are left fully random so that every input bit toggles.
  function automatic logic [63:0] random_row(input logic [7:0] pal [5]);
    logic [63:0] row;
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 9))
        0: row[63 - 8 * p -: 8] = 8'd0;
        1: row[63 - 8 * p -: 8] = 8'($urandom);
        default: row[63 - 8 * p -: 8] = pal[$urandom_range(0, 4)];
      endcase
    end
    return row;
  endfunction

  row_step_t   steps [$];
  logic [7:0]  pal [5];

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    row_pixels_i = '0;
    band_start_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    idle_cycles = 0;
    no_gaps = 0;
    mdl_default = 8'd0;
    mdl_sprite = 1'b0;
    mdl_row_idx = '0;
    mdl_ink = InkReset;
    mdl_paper = PaperReset;
    for (int i = 0; i < ColorCount; i++) begin
      mdl_hist[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed cells. The first cell is empty, which sends both ink and
    // paper to the default colour 0, so its attribute is 0. The next cell
    // has every pixel at 0xFF with a band start on a later row, which gives
    // ink 7 with bright set over paper 0. The last one is a busy mixed cell
    // whose attribute comes from the predictor.
    for (int r = 0; r < 8; r++) begin
      steps.push_back('{64'd0, 1'b0, r == 7, 8'h00});
    end
    for (int r = 0; r < 8; r++) begin
      steps.push_back('{{8{8'hff}}, r == 3, r == 7, 8'h47});
    end
    for (int r = 0; r < 8; r++) begin
      steps.push_back('{64'h0102_0a09_1112_0807 ^ {8{8'(r)}}, r == 0, 1'b0, 8'h00});
    end
    foreach (steps[k]) begin
      send_row(steps[k].row, steps[k].band);
      if (steps[k].has_attr && last_attr_due !== steps[k].attr) begin
        $error("attribute expected %h actual %h", steps[k].attr, last_attr_due);
        errors++;
      end
    end
    drain();

    // Random part. Each phase uses its own register setting, and the
    // extremes of the default colour and both sprite modes are included.
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(RegDefaultColor, (ph == 0) ? 8'hff : (ph == 3) ? 8'h00 : 8'($urandom));
      reg_write(RegSpriteMode, {7'd0, ph[0]});
      no_gaps = (ph == 3);
      for (int cell_idx = 0; cell_idx < RandomRows / 32; cell_idx++) begin
        for (int i = 0; i < 5; i++) begin
          pal[i] = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 16)) : 8'($urandom);
        end
        for (int r = 0; r < 8; r++) begin
          send_row(random_row(pal), (r == 0) ? ($urandom_range(0, 3) == 0)
                                              : ($urandom_range(0, 15) == 0));
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
